// ----- sv/dll_pkg.sv -----
// package: pool sizing, codes and controller/datapath command and status types
package dll_pkg;

  localparam int POOL_DEPTH = 32;
  localparam int AW         = $clog2(POOL_DEPTH);
  localparam int IDX_W      = $clog2(POOL_DEPTH + 1);
  localparam int LEN_W      = IDX_W;

  localparam logic [IDX_W-1:0] NIL_IDX = IDX_W'(POOL_DEPTH);

  localparam logic [2:0] FN_APPEND   = 3'd0;
  localparam logic [2:0] FN_INSERT   = 3'd1;
  localparam logic [2:0] FN_REM_HEAD = 3'd2;
  localparam logic [2:0] FN_REM_TAIL = 3'd3;
  localparam logic [2:0] FN_REM_VAL  = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [1:0] RD_FREE = 2'd0;
  localparam logic [1:0] RD_HEAD = 2'd1;
  localparam logic [1:0] RD_TAIL = 2'd2;
  localparam logic [1:0] RD_NEXT = 2'd3;

  typedef struct packed {
    logic       latch_op;
    logic       rd_en;
    logic [1:0] rd_src;
    logic       alloc;
    logic       link;
    logic       unlink;
    logic       release_node;
    logic       set_status;
    logic [1:0] status;
    logic       out_load;
  } dll_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       free_nil;
    logic       head_live;
    logic       tail_live;
    logic       count_zero;
    logic       match;
    logic       walk_end;
    logic       out_busy;
  } dll_sts_t;

endpackage

// ----- sv/dll_if.sv -----
// interfaces: request and response channels
interface dll_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         func;
  logic signed [31:0] value;
  modport source (output valid, func, value, input ready);
  modport sink   (input valid, func, value, output ready);
endinterface

interface dll_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] removed_value;
  logic [5:0]         length;
  modport source (output valid, status, removed_value, length, input ready);
  modport sink   (input valid, status, removed_value, length, output ready);
endinterface

// ----- sv/dll_datapath.sv -----
// datapath: node memories, list pointers, free list and result register
module dll_datapath import dll_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dll_cmd_t           cmd,
  output dll_sts_t           sts,
  input  logic [2:0]         func,
  input  logic signed [31:0] value,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [1:0]         rsp_status,
  output logic signed [31:0] rsp_removed_value,
  output logic [LEN_W-1:0]   rsp_length
);

  logic [31:0]      value_mem [POOL_DEPTH];
  logic [IDX_W-1:0] next_mem  [POOL_DEPTH];
  logic [IDX_W-1:0] prev_mem  [POOL_DEPTH];

  logic [31:0]      rvalue;
  logic [IDX_W-1:0] rnext;
  logic [IDX_W-1:0] rprev;

  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] hw;
  logic [IDX_W-1:0] count;
  logic [IDX_W-1:0] cur;
  logic [IDX_W-1:0] k;
  logic [2:0]       op_func;
  logic [31:0]      op_value;
  logic [1:0]       res_status;
  logic [31:0]      res_removed;

  logic [IDX_W-1:0] rd_addr;
  logic             value_we;
  logic             next_we;
  logic             prev_we;
  logic [IDX_W-1:0] next_wa;
  logic [IDX_W-1:0] prev_wa;
  logic [IDX_W-1:0] next_wd;
  logic [IDX_W-1:0] prev_wd;

  function automatic logic live(input logic [IDX_W-1:0] i);
    return i < NIL_IDX;
  endfunction

  always_comb begin
    case (cmd.rd_src)
      RD_FREE: rd_addr = free_idx;
      RD_HEAD: rd_addr = head;
      RD_TAIL: rd_addr = tail;
      default: rd_addr = rnext;
    endcase
  end

  always_comb begin
    value_we = cmd.alloc;
    next_we  = 1'b0;
    prev_we  = 1'b0;
    next_wa  = cur;
    prev_wa  = cur;
    next_wd  = NIL_IDX;
    prev_wd  = NIL_IDX;
    if (cmd.alloc) begin
      next_we = 1'b1;
      prev_we = 1'b1;
      next_wd = (op_func == FN_APPEND) ? NIL_IDX : head;
      prev_wd = (op_func == FN_APPEND) ? tail : NIL_IDX;
    end else if (cmd.link) begin
      if (op_func == FN_APPEND) begin
        next_we = live(tail);
        next_wa = tail;
        next_wd = cur;
      end else begin
        prev_we = live(head);
        prev_wa = head;
        prev_wd = cur;
      end
    end else if (cmd.unlink) begin
      next_we = live(rprev);
      next_wa = rprev;
      next_wd = rnext;
      prev_we = live(rnext);
      prev_wa = rnext;
      prev_wd = rprev;
    end else if (cmd.release_node) begin
      next_we = 1'b1;
      next_wa = cur;
      next_wd = free_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (value_we) value_mem[cur[AW-1:0]] <= op_value;
    if (next_we) next_mem[next_wa[AW-1:0]] <= next_wd;
    if (prev_we) prev_mem[prev_wa[AW-1:0]] <= prev_wd;
    if (cmd.rd_en) begin
      rvalue <= value_mem[rd_addr[AW-1:0]];
      rnext  <= next_mem[rd_addr[AW-1:0]];
      rprev  <= prev_mem[rd_addr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= NIL_IDX;
      tail      <= NIL_IDX;
      free_idx  <= '0;
      hw        <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.alloc) begin
        // untouched entries above the fill mark chain to their neighbor
        if (free_idx == hw) begin
          free_idx <= hw + IDX_W'(1);
          hw       <= hw + IDX_W'(1);
        end else begin
          free_idx <= rnext;
        end
      end
      if (cmd.link) begin
        if (op_func == FN_APPEND) begin
          if (!live(tail)) head <= cur;
          tail <= cur;
        end else begin
          if (!live(head)) tail <= cur;
          head <= cur;
        end
        count <= count + IDX_W'(1);
      end
      if (cmd.unlink) begin
        if (!live(rprev)) head <= rnext;
        if (!live(rnext)) tail <= rprev;
      end
      if (cmd.release_node) begin
        free_idx <= cur;
        if (count != '0) count <= count - IDX_W'(1);
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_op) begin
      op_func     <= func;
      op_value    <= $unsigned(value);
      res_status  <= ST_OK;
      res_removed <= '0;
    end
    if (cmd.set_status) res_status <= cmd.status;
    if (cmd.unlink) res_removed <= rvalue;
    if (cmd.rd_en) begin
      cur <= rd_addr;
      k   <= (cmd.rd_src == RD_NEXT) ? k + IDX_W'(1) : '0;
    end
    if (cmd.out_load) begin
      rsp_status        <= res_status;
      rsp_removed_value <= $signed(res_removed);
      rsp_length        <= count;
    end
  end

  always_comb begin
    sts.func       = op_func;
    sts.free_nil   = !live(free_idx);
    sts.head_live  = live(head);
    sts.tail_live  = live(tail);
    sts.count_zero = (count == '0);
    sts.match      = (op_func != FN_REM_VAL) || (rvalue == op_value);
    sts.walk_end   = (k + IDX_W'(1) == count) || !live(rnext);
    sts.out_busy   = rsp_valid && !rsp_ready;
  end

endmodule

// ----- sv/dll_ctrl.sv -----
// controller: sequences each operation over the datapath
module dll_ctrl import dll_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  dll_sts_t sts,
  output dll_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_LINK  = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_FREE  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch_op = 1'b1;
          state_next   = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.func)
          FN_APPEND, FN_INSERT: begin
            if (sts.free_nil) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FULL;
              state_next     = S_FIN;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = RD_FREE;
              state_next = S_ALLOC;
            end
          end
          FN_REM_HEAD, FN_REM_VAL, FN_REM_TAIL: begin
            if (sts.count_zero ||
                !((sts.func == FN_REM_TAIL) ? sts.tail_live : sts.head_live)) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
              state_next     = S_FIN;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = (sts.func == FN_REM_TAIL) ? RD_TAIL : RD_HEAD;
              state_next = S_CHK;
            end
          end
          default: state_next = S_FIN;
        endcase
      end
      S_ALLOC: begin
        cmd.alloc  = 1'b1;
        state_next = S_LINK;
      end
      S_LINK: begin
        cmd.link   = 1'b1;
        state_next = S_FIN;
      end
      S_CHK: begin
        if (sts.match) begin
          cmd.unlink = 1'b1;
          state_next = S_FREE;
        end else if (sts.walk_end) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_NOT_FOUND;
          state_next     = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_NEXT;
        end
      end
      S_FREE: begin
        cmd.release_node = 1'b1;
        state_next       = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/doubly_linked_list_engine_top.sv -----
// top level: doubly linked list engine
//
//  channel | dir | fields
//  req     | in  | func[2:0], value[31:0] signed
//  rsp     | out | status[1:0], removed_value[31:0] signed, length[5:0]
//
// append or insert: dispatch, alloc, link and finish states after the req transfer
// remove: dispatch, check (a walk from the head for by value), free and finish states
// empty, full, not found and unused codes: the finish state follows dispatch or check
// synchronous reset; no clearing pass, a fill mark stands in for the initial free chain
// a new request is taken while a result waits; the next result holds until rsp transfers
module doubly_linked_list_engine_top import dll_pkg::*; (
  input logic      clk,
  input logic      rst,
  dll_req_if.sink  req,
  dll_rsp_if.source rsp
);

  dll_cmd_t cmd;
  dll_sts_t sts;

  dll_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dll_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .func              (req.func),
    .value             (req.value),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_removed_value (rsp.removed_value),
    .rsp_length        (rsp.length)
  );

endmodule

// ----- sv/dll_checker.sv -----
// checker: port level assertions, bound to the top level
module dll_checker import dll_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [1:0]         status,
  input logic signed [31:0] removed_value,
  input logic [5:0]         length
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) &&
      $stable(removed_value) && $stable(length))
    else $error("rsp changed while stalled");

  a_len_max: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> length <= 6'(POOL_DEPTH))
    else $error("length beyond pool");

  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> length == 6'(POOL_DEPTH) && removed_value == 0)
    else $error("full with free nodes");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_EMPTY |-> length == 6'd0 && removed_value == 0)
    else $error("empty with nodes");

  a_not_found: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_NOT_FOUND |-> length != 6'd0 && removed_value == 0)
    else $error("not found on empty list");

endmodule

bind doubly_linked_list_engine_top dll_checker u_chk (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .status        (rsp.status),
  .removed_value (rsp.removed_value),
  .length        (rsp.length)
);

// ----- tb/sv/tb_doubly_linked_list_engine_top.sv -----
// testbench: doubly linked list engine, random and directed operations against a list predictor
`timescale 1ns / 1ps
module tb_doubly_linked_list_engine_top;
  import dll_pkg::*;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] removed_value;
    logic [5:0]  length;
  } dll_result_t;

  logic clk;
  logic rst;
  dll_req_if req ();
  dll_rsp_if rsp ();

  doubly_linked_list_engine_top dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  // list contents, head first
  logic [31:0] list_vals[$];
  dll_result_t result_q[$];
  int errors;
  int results_seen;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  longint cycles;
  int op_hist[8];
  int status_hist[4];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd3000000) begin
      $display("timeout at %0t", $time);
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic dll_result_t list_apply(logic [2:0] fn, logic [31:0] v);
    dll_result_t r;
    int idx;
    r.status = ST_OK;
    r.removed_value = '0;
    idx = -1;
    case (fn)
      FN_APPEND, FN_INSERT: begin
        if (list_vals.size() >= POOL_DEPTH) r.status = ST_FULL;
        else if (fn == FN_APPEND) list_vals.push_back(v);
        else list_vals.push_front(v);
      end
      FN_REM_HEAD: begin
        if (list_vals.size() == 0) r.status = ST_EMPTY;
        else r.removed_value = list_vals.pop_front();
      end
      FN_REM_TAIL: begin
        if (list_vals.size() == 0) r.status = ST_EMPTY;
        else r.removed_value = list_vals.pop_back();
      end
      FN_REM_VAL: begin
        if (list_vals.size() == 0) r.status = ST_EMPTY;
        else begin
          foreach (list_vals[i])
            if (idx < 0 && list_vals[i] == v) idx = i;
          if (idx < 0) r.status = ST_NOT_FOUND;
          else begin
            r.removed_value = list_vals[idx];
            list_vals.delete(idx);
          end
        end
      end
      default: ;
    endcase
    r.length = 6'(list_vals.size());
    return r;
  endfunction

  task automatic send_op(logic [2:0] fn, logic [31:0] v);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk);
    req.valid <= 1'b1;
    req.func <= fn;
    req.value <= v;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    result_q.push_back(list_apply(fn, v));
    op_hist[fn]++;
    req.valid <= 1'b0;
    @(posedge clk);
  endtask

  // receiver ready
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    dll_result_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      results_seen++;
      if (result_q.size() == 0) begin
        $display("%0t unexpected result status=%0d removed=%0h length=%0d", $time,
                 rsp.status, rsp.removed_value, rsp.length);
        errors++;
      end else begin
        e = result_q.pop_front();
        status_hist[rsp.status]++;
        if (rsp.status !== e.status || rsp.removed_value !== e.removed_value ||
            rsp.length !== e.length) begin
          $display("%0t mismatch expected status=%0d removed=%0h length=%0d", $time,
                   e.status, e.removed_value, e.length);
          $display("%0t          actual   status=%0d removed=%0h length=%0d", $time,
                   rsp.status, rsp.removed_value, rsp.length);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    while (result_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    v = $urandom();
    if (list_vals.size() != 0 && $urandom_range(99) < 60)
      v = list_vals[$urandom_range(list_vals.size() - 1)];
    else if ($urandom_range(3) == 0)
      v = 32'($urandom_range(7));
    return v;
  endfunction

  task automatic test_directed();
    send_op(FN_REM_HEAD, 32'd0);
    send_op(FN_REM_TAIL, 32'd0);
    send_op(FN_REM_VAL, 32'h8000_0000);
    send_op(FN_APPEND, 32'h8000_0000);
    send_op(FN_INSERT, 32'h7fff_ffff);
    send_op(FN_APPEND, 32'hffff_ffff);
    send_op(FN_INSERT, 32'd0);
    send_op(FN_REM_VAL, 32'h1234_5678);
    send_op(FN_REM_VAL, 32'hffff_ffff);
    send_op(3'd5, 32'h5555_5555);
    send_op(3'd6, 32'haaaa_aaaa);
    send_op(3'd7, 32'd1);
    send_op(FN_REM_HEAD, 32'd0);
    send_op(FN_REM_TAIL, 32'd0);
    send_op(FN_REM_VAL, 32'h8000_0000);
    send_op(FN_REM_VAL, 32'h8000_0000);
  endtask

  task automatic test_pool_full();
    for (int i = 0; i < POOL_DEPTH + 2; i++) send_op(3'($urandom_range(1)), $urandom());
    send_op(FN_REM_VAL, list_vals[POOL_DEPTH - 1]);
    send_op(FN_REM_VAL, list_vals[0]);
    while (list_vals.size() != 0) send_op(3'($urandom_range(2, 4)), pick_value());
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) send_op(3'($urandom_range(1)), $urandom());
    drain();
  endtask

  task automatic test_random(int n, int idle, int stall);
    logic [2:0] fn;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) fn = 3'($urandom_range(5, 7));
      else if (list_vals.size() < 4) fn = 3'($urandom_range(9) < 7 ? $urandom_range(1)
                                                                 : $urandom_range(2, 4));
      else if (list_vals.size() > 28) fn = 3'($urandom_range(9) < 7 ? $urandom_range(2, 4)
                                                                  : $urandom_range(1));
      else fn = 3'($urandom_range(4));
      send_op(fn, pick_value());
    end
    drain();
  endtask

  initial begin
    errors = 0;
    results_seen = 0;
    cycles = 0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.func = '0;
    req.value = '0;
    rsp.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_pool_full();
    drain();
    test_backpressure();
    test_random(350, 0, 0);
    test_random(300, 86, 0);
    test_random(300, 0, 86);
    test_random(250, 8, 8);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (60) @(posedge clk);
    $display("covered %0d results: ops %0d/%0d/%0d/%0d/%0d, unused %0d", results_seen,
             op_hist[0], op_hist[1], op_hist[2], op_hist[3], op_hist[4],
             op_hist[5] + op_hist[6] + op_hist[7]);
    $display("statuses ok %0d, empty %0d, not found %0d, full %0d", status_hist[0],
             status_hist[1], status_hist[2], status_hist[3]);
    if (errors == 0 && result_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/dll_pkg.sv
sv/dll_if.sv
sv/dll_datapath.sv
sv/dll_ctrl.sv
sv/doubly_linked_list_engine_top.sv
sv/dll_checker.sv
tb/sv/tb_doubly_linked_list_engine_top.sv
